// ===== src/sbbt_pkg.sv =====
package sbbt_pkg;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic [15:0]        yaw;
        logic [30:0]        radius;
        logic               pass_through;
    } t_in;

    typedef struct packed {
        logic blocked;
        logic status;
    } t_out;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_TEST   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int TBITS = 24;
    localparam int CSTEPS = 17;
    localparam int MSTEPS = 8;
    localparam logic signed [33:0] CGAIN = 34'sd652032874;
    localparam logic signed [63:0] MIN_MOVE = 64'sd7;
    localparam logic [24:0] TONE = 25'd16777216;

    typedef enum logic [4:0] {
        S_IDLE, S_OUT, S_FETCH, S_CINIT, S_CORDIC, S_CFIN,
        S_DIFF, S_MUL, S_ROT, S_AXIS, S_DIVSEL, S_DIV, S_CMP, S_NEXT
    } t_state;

    function automatic logic signed [33:0] atan_c(input logic [4:0] i);
        logic signed [33:0] v;
        begin
            case (i)
                5'd0: v = 34'sd131072;  5'd1: v = 34'sd77376;
                5'd2: v = 34'sd40884;   5'd3: v = 34'sd20753;
                5'd4: v = 34'sd10417;   5'd5: v = 34'sd5214;
                5'd6: v = 34'sd2607;    5'd7: v = 34'sd1304;
                5'd8: v = 34'sd652;     5'd9: v = 34'sd326;
                5'd10: v = 34'sd163;    5'd11: v = 34'sd81;
                5'd12: v = 34'sd41;     5'd13: v = 34'sd20;
                5'd14: v = 34'sd10;     5'd15: v = 34'sd5;
                5'd16: v = 34'sd3;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== src/segment_box_block_test.sv =====
// Channel  Direction  Payload           Handshake
// in       input      sbbt_pkg::t_in    i_in_valid / o_in_stall
// out      output     sbbt_pkg::t_out   o_out_valid / i_out_stall
// Clear, add and the unused command go from S_IDLE, which accepts the request,
// straight to S_OUT, which presents the result. A test visits each stored box in
// turn (17 CORDIC steps, 8 multiply steps, then per axis up to two 24-step
// restoring divisions), stopping at the first hit.
// The box table is a memory read one entry per box visit.
// Reset clears the box count and the sequencer; a stalled result holds.
module segment_box_block_test #(
    parameter int MAX_BOXES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sbbt_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sbbt_pkg::t_out  o_out
);
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef struct packed {
        logic signed [31:0] cx, cy, cz, hx, hy, hz;
        logic [15:0]        ang;
    } t_box;

    t_box mem [MAX_BOXES];
    t_box r_box;

    sbbt_pkg::t_state r_state, n_state;
    sbbt_pkg::t_in    r_req;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_k;
    logic             r_blk, r_sts;
    logic [4:0]       r_i;
    logic [1:0]       r_ax;
    logic [1:0]       r_quad;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [31:0] r_c, r_s;
    logic signed [32:0] r_fx, r_fz, r_tx, r_tz;
    logic signed [64:0] r_acc;
    logic signed [63:0] r_m [4];
    logic signed [63:0] r_st [3];
    logic signed [63:0] r_mv [3];
    logic signed [63:0] r_n1, r_n2, r_d;
    logic               r_sel;
    logic [63:0]        r_r;
    logic [24:0]        r_q, r_t1, r_enter, r_leave;
    logic               r_fail;

    assign o_in_stall  = (r_state != sbbt_pkg::S_IDLE);
    assign o_out_valid = (r_state == sbbt_pkg::S_OUT);
    assign o_out.blocked = r_blk;
    assign o_out.status  = r_sts;

    wire acc = i_in_valid && !o_in_stall;

    // Current axis values.
    logic signed [63:0] a_st, a_mv, a_hf, a_mst, a_mmv, a_n1, a_n2, a_d, a_num;
    logic signed [31:0] a_half;
    always_comb begin
        case (r_ax)
            2'd0: a_half = r_box.hx;
            2'd1: a_half = r_box.hy;
            default: a_half = r_box.hz;
        endcase
        a_st = r_st[r_ax];
        a_mv = r_mv[r_ax];
        a_hf = 64'(a_half) + 64'($signed({1'b0, r_req.radius}));
        a_mst = a_st[63] ? -a_st : a_st;
        a_mmv = a_mv[63] ? -a_mv : a_mv;
        a_n1 = -a_hf - a_st;
        a_n2 = a_hf - a_st;
        if (a_mv[63]) begin
            a_n1 = -a_n1; a_n2 = -a_n2; a_d = -a_mv;
        end else begin
            a_d = a_mv;
        end
        a_num = r_sel ? r_n2 : r_n1;
    end

    // Shift terms for the CORDIC steps and the shift/compare for the division steps.
    logic signed [33:0] sh_y, sh_x;
    logic [64:0] dv_r2;
    logic        dv_ge;
    always_comb begin
        sh_y = r_y >>> r_i;
        sh_x = r_x >>> r_i;
        dv_r2 = {r_r, 1'b0};
        dv_ge = (dv_r2 >= {1'b0, r_d});
    end

    // One multiplier forms the eight rotation products in turn; each odd step
    // completes one rotated coordinate.
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p, mul_sum;
    always_comb begin
        mul_a = r_i[2] ? (r_i[0] ? r_tz : r_tx) : (r_i[0] ? r_fz : r_fx);
        mul_b = (r_i[0] == r_i[1]) ? r_c : r_s;
        mul_p = mul_a * mul_b;
        mul_sum = (r_i[0] ? r_acc : 65'sd0) + ((r_i[0] && !r_i[1]) ? -mul_p : mul_p);
    end

    logic signed [33:0] cr, sr;
    always_comb begin
        cr = (r_x + 34'sd8192) >>> 14;
        sr = (r_y + 34'sd8192) >>> 14;
    end

    logic [24:0] c_enter, c_leave;
    logic        c_fail;
    always_comb begin
        c_enter = (r_t1 > r_enter) ? r_t1 : r_enter;
        c_leave = (r_q < r_leave) ? r_q : r_leave;
        c_fail  = (c_enter > c_leave);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbbt_pkg::S_IDLE: begin
                if (acc) begin
                    if (i_in.command == sbbt_pkg::CMD_TEST && !i_in.pass_through
                        && r_count != '0) n_state = sbbt_pkg::S_FETCH;
                    else n_state = sbbt_pkg::S_OUT;
                end
            end
            sbbt_pkg::S_OUT:    if (!i_out_stall) n_state = sbbt_pkg::S_IDLE;
            sbbt_pkg::S_FETCH:  n_state = sbbt_pkg::S_CINIT;
            sbbt_pkg::S_CINIT:  n_state = sbbt_pkg::S_CORDIC;
            sbbt_pkg::S_CORDIC: if (r_i == 5'(sbbt_pkg::CSTEPS - 1)) n_state = sbbt_pkg::S_CFIN;
            sbbt_pkg::S_CFIN:   n_state = sbbt_pkg::S_DIFF;
            sbbt_pkg::S_DIFF:   n_state = sbbt_pkg::S_MUL;
            sbbt_pkg::S_MUL:    if (r_i == 5'(sbbt_pkg::MSTEPS - 1)) n_state = sbbt_pkg::S_ROT;
            sbbt_pkg::S_ROT:    n_state = sbbt_pkg::S_AXIS;
            sbbt_pkg::S_AXIS: begin
                if (a_mmv < sbbt_pkg::MIN_MOVE) begin
                    if (a_mst > a_hf) n_state = sbbt_pkg::S_NEXT;
                    else if (r_ax == 2'd2) n_state = sbbt_pkg::S_NEXT;
                end else n_state = sbbt_pkg::S_DIVSEL;
            end
            sbbt_pkg::S_DIVSEL: begin
                if (a_num <= 0 || a_num >= r_d) n_state = r_sel ? sbbt_pkg::S_CMP
                                                                 : sbbt_pkg::S_DIVSEL;
                else n_state = sbbt_pkg::S_DIV;
            end
            sbbt_pkg::S_DIV: begin
                if (r_i == 5'(sbbt_pkg::TBITS - 1))
                    n_state = r_sel ? sbbt_pkg::S_CMP : sbbt_pkg::S_DIVSEL;
            end
            sbbt_pkg::S_CMP: begin
                if (c_fail || r_ax == 2'd2) n_state = sbbt_pkg::S_NEXT;
                else n_state = sbbt_pkg::S_AXIS;
            end
            sbbt_pkg::S_NEXT: begin
                if (!r_fail || r_k == r_count) n_state = sbbt_pkg::S_OUT;
                else n_state = sbbt_pkg::S_FETCH;
            end
            default: n_state = sbbt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbbt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                if (i_in.command == sbbt_pkg::CMD_CLEAR) r_count <= '0;
                else if (i_in.command == sbbt_pkg::CMD_ADD && r_count < CW'(MAX_BOXES))
                    r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_in.command == sbbt_pkg::CMD_ADD && r_count < CW'(MAX_BOXES))
            mem[r_count[AW-1:0]] <= '{i_in.px, i_in.py, i_in.pz,
                                      i_in.qx, i_in.qy, i_in.qz, i_in.yaw};
        if (r_state == sbbt_pkg::S_FETCH) r_box <= mem[r_k[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        logic [15:0] rem;
        logic [1:0]  qd;
        unique case (r_state)
            sbbt_pkg::S_IDLE: if (acc) begin
                r_req <= i_in;
                r_k   <= '0;
                r_blk <= 1'b0;
                r_sts <= (i_in.command == sbbt_pkg::CMD_ADD) && (r_count >= CW'(MAX_BOXES));
                r_fail <= 1'b0;
            end
            sbbt_pkg::S_FETCH: r_k <= r_k + 1'b1;
            sbbt_pkg::S_CINIT: begin
                qd = 2'((r_box.ang + 16'h2000) >> 14);
                rem = r_box.ang - {qd, 14'd0};
                r_quad <= qd;
                r_z <= 34'($signed(rem)) * 34'sd16;
                r_x <= sbbt_pkg::CGAIN;
                r_y <= '0;
                r_i <= '0;
            end
            sbbt_pkg::S_CORDIC: begin
                if (!r_z[33]) begin
                    r_x <= r_x - sh_y; r_y <= r_y + sh_x;
                    r_z <= r_z - sbbt_pkg::atan_c(r_i);
                end else begin
                    r_x <= r_x + sh_y; r_y <= r_y - sh_x;
                    r_z <= r_z + sbbt_pkg::atan_c(r_i);
                end
                r_i <= r_i + 1'b1;
            end
            sbbt_pkg::S_CFIN: begin
                case (r_quad)
                    2'd0: begin r_c <= 32'(cr);  r_s <= 32'(sr);  end
                    2'd1: begin r_c <= 32'(-sr); r_s <= 32'(cr);  end
                    2'd2: begin r_c <= 32'(-cr); r_s <= 32'(-sr); end
                    default: begin r_c <= 32'(sr); r_s <= 32'(-cr); end
                endcase
            end
            sbbt_pkg::S_DIFF: begin
                r_fx <= 33'(r_req.px) - 33'(r_box.cx);
                r_fz <= 33'(r_req.pz) - 33'(r_box.cz);
                r_tx <= 33'(r_req.qx) - 33'(r_box.cx);
                r_tz <= 33'(r_req.qz) - 33'(r_box.cz);
                r_i <= '0;
            end
            sbbt_pkg::S_MUL: begin
                r_acc <= mul_sum;
                if (r_i[0]) r_m[r_i[2:1]] <= 64'((mul_sum + 65'sd32768) >>> 16);
                r_i <= r_i + 1'b1;
            end
            sbbt_pkg::S_ROT: begin
                r_st[0] <= r_m[0];
                r_st[2] <= r_m[1];
                r_st[1] <= 64'(r_req.py) - 64'(r_box.cy);
                r_mv[0] <= r_m[2] - r_m[0];
                r_mv[2] <= r_m[3] - r_m[1];
                r_mv[1] <= 64'(r_req.qy) - 64'(r_req.py);
                r_ax <= 2'd0;
                r_enter <= '0;
                r_leave <= sbbt_pkg::TONE;
                r_fail <= 1'b0;
            end
            sbbt_pkg::S_AXIS: begin
                r_sel <= 1'b0;
                if (a_mmv < sbbt_pkg::MIN_MOVE) begin
                    if (a_mst > a_hf) r_fail <= 1'b1;
                    else r_ax <= r_ax + 1'b1;
                end else begin
                    r_d <= a_d;
                    if (a_n1 > a_n2) begin r_n1 <= a_n2; r_n2 <= a_n1; end
                    else begin r_n1 <= a_n1; r_n2 <= a_n2; end
                end
            end
            sbbt_pkg::S_DIVSEL: begin
                r_r <= 64'(a_num);
                r_i <= '0;
                if ((a_num <= 0 || a_num >= r_d) && r_sel)
                    r_q <= (a_num <= 0) ? 25'd0 : sbbt_pkg::TONE;
                else r_q <= '0;
                if ((a_num <= 0 || a_num >= r_d) && !r_sel) begin
                    r_t1 <= (a_num <= 0) ? 25'd0 : sbbt_pkg::TONE;
                    r_sel <= 1'b1;
                end
            end
            sbbt_pkg::S_DIV: begin
                r_r <= dv_ge ? 64'(dv_r2 - {1'b0, r_d}) : dv_r2[63:0];
                r_q <= {r_q[23:0], dv_ge};
                r_i <= r_i + 1'b1;
                if (r_i == 5'(sbbt_pkg::TBITS - 1) && !r_sel) begin
                    r_t1 <= {r_q[23:0], dv_ge};
                    r_sel <= 1'b1;
                end
            end
            sbbt_pkg::S_CMP: begin
                if (c_fail) r_fail <= 1'b1;
                r_enter <= c_enter;
                r_leave <= c_leave;
                r_ax <= r_ax + 1'b1;
            end
            sbbt_pkg::S_NEXT: begin
                if (!r_fail) r_blk <= 1'b1;
                r_fail <= 1'b0;
            end
            default: ;
        endcase
    end
endmodule

// ===== src/sbbt_checker.sv =====
module sbbt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input sbbt_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input sbbt_pkg::t_out o_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken while result pending");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.blocked && o_out.status))
        else $error("blocked and status both set");
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.command == sbbt_pkg::CMD_CLEAR
        |=> o_out_valid && !o_out.blocked && !o_out.status)
        else $error("clear gave a nonzero result");
endmodule

bind segment_box_block_test sbbt_checker u_chk (.*);

// ===== dv/tb_segment_box_block_test.sv =====
`timescale 1ns / 1ps

module tb_segment_box_block_test;

    localparam int NUM_BOXES = 64;
    localparam int RANDOM_REQUESTS = 1088;

    typedef struct packed {
        logic blocked;
        logic status;
        logic check_fixed;
    } t_row_expect;

    typedef struct {
        sbbt_pkg::t_in req;
        t_row_expect   exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    sbbt_pkg::t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    sbbt_pkg::t_out o_out;

    longint box_cx [NUM_BOXES];
    longint box_cy [NUM_BOXES];
    longint box_cz [NUM_BOXES];
    longint box_hx [NUM_BOXES];
    longint box_hy [NUM_BOXES];
    longint box_hz [NUM_BOXES];
    logic [15:0] box_yaw [NUM_BOXES];
    int box_total;

    sbbt_pkg::t_out pending_results [$];
    int fail_count;
    bit quiet_tail;
    int sent_count;
    t_row plan [$];

    segment_box_block_test #(.MAX_BOXES(NUM_BOXES)) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint abs_val(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint atan_step(int i);
        longint tbl [17] = '{131072, 77376, 40884, 20753, 10417, 5214, 2607, 1304,
                             652, 326, 163, 81, 41, 20, 10, 5, 3};
        return tbl[i];
    endfunction

    function automatic void yaw_sin_cos(input logic [15:0] ang, output longint c_o,
                                        output longint s_o);
        logic [15:0] quad_base;
        logic [1:0] quad;
        longint rem, x, y, z, dx, dy, c, s;
        quad = 2'((32'(ang) + 32'h2000) >> 14);
        quad_base = ang - {quad, 14'd0};
        rem = longint'(quad_base);
        if (rem >= 32768) rem -= 65536;
        x = 652032874;
        y = 0;
        z = rem * 16;
        for (int i = 0; i < 17; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = floor_shift(x + 8192, 14);
        s = floor_shift(y + 8192, 14);
        case (quad)
            2'd0: begin c_o = c; s_o = s; end
            2'd1: begin c_o = -s; s_o = c; end
            2'd2: begin c_o = -c; s_o = -s; end
            default: begin c_o = s; s_o = -c; end
        endcase
    endfunction

    function automatic longint clipped_time(longint n, longint d);
        longint q, r;
        if (n <= 0) return 0;
        if (n >= d) return longint'(1) << 24;
        q = 0;
        r = n;
        for (int i = 0; i < 24; i++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= d) begin
                r -= d;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic bit segment_hits_box(int k, sbbt_pkg::t_in req);
        longint c, s, fx, fz, tx, tz, n1, n2, d, t1, t2, tmp;
        longint st [3];
        longint mv [3];
        longint hf [3];
        longint enter_t, leave_t, rad;
        yaw_sin_cos(box_yaw[k], c, s);
        rad = longint'(req.radius);
        fx = longint'(req.px) - box_cx[k];
        fz = longint'(req.pz) - box_cz[k];
        tx = longint'(req.qx) - box_cx[k];
        tz = longint'(req.qz) - box_cz[k];
        st[0] = floor_shift(fx * c - fz * s + 32768, 16);
        st[1] = longint'(req.py) - box_cy[k];
        st[2] = floor_shift(fx * s + fz * c + 32768, 16);
        mv[0] = floor_shift(tx * c - tz * s + 32768, 16) - st[0];
        mv[1] = (longint'(req.qy) - box_cy[k]) - st[1];
        mv[2] = floor_shift(tx * s + tz * c + 32768, 16) - st[2];
        hf[0] = box_hx[k] + rad;
        hf[1] = box_hy[k] + rad;
        hf[2] = box_hz[k] + rad;
        enter_t = 0;
        leave_t = longint'(1) << 24;
        for (int ax = 0; ax < 3; ax++) begin
            if (abs_val(mv[ax]) < 7) begin
                if (abs_val(st[ax]) > hf[ax]) return 1'b0;
                continue;
            end
            n1 = -hf[ax] - st[ax];
            n2 = hf[ax] - st[ax];
            d = mv[ax];
            if (d < 0) begin
                d = -d; n1 = -n1; n2 = -n2;
            end
            if (n1 > n2) begin
                tmp = n1; n1 = n2; n2 = tmp;
            end
            t1 = clipped_time(n1, d);
            t2 = clipped_time(n2, d);
            if (t1 > enter_t) enter_t = t1;
            if (t2 < leave_t) leave_t = t2;
            if (enter_t > leave_t) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic sbbt_pkg::t_out apply_command(sbbt_pkg::t_in req);
        sbbt_pkg::t_out res;
        res = '0;
        case (req.command)
            sbbt_pkg::CMD_CLEAR: box_total = 0;
            sbbt_pkg::CMD_ADD: begin
                if (box_total < NUM_BOXES) begin
                    box_cx[box_total] = longint'(req.px);
                    box_cy[box_total] = longint'(req.py);
                    box_cz[box_total] = longint'(req.pz);
                    box_hx[box_total] = longint'(req.qx);
                    box_hy[box_total] = longint'(req.qy);
                    box_hz[box_total] = longint'(req.qz);
                    box_yaw[box_total] = req.yaw;
                    box_total++;
                end else begin
                    res.status = 1'b1;
                end
            end
            sbbt_pkg::CMD_TEST: begin
                if (!req.pass_through) begin
                    for (int k = 0; k < box_total; k++) begin
                        if (segment_hits_box(k, req)) begin
                            res.blocked = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return 32'($signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    function automatic sbbt_pkg::t_in random_request(int bias);
        sbbt_pkg::t_in r;
        r = '0;
        r.px = rand_coord();
        r.py = rand_coord();
        r.pz = rand_coord();
        r.qx = rand_coord();
        r.qy = rand_coord();
        r.qz = rand_coord();
        r.yaw = 16'($urandom());
        r.radius = ($urandom_range(0, 7) == 0) ? 31'($urandom()) :
                   31'($urandom_range(0, 3 << 16));
        r.pass_through = ($urandom_range(0, 7) == 0);
        if (bias < 5) begin
            r.command = 2'($urandom());
        end else if (bias < 45) begin
            r.command = sbbt_pkg::CMD_ADD;
            if ($urandom_range(0, 3) != 0) begin
                r.qx = 32'($urandom_range(1 << 14, 6 << 16));
                r.qy = 32'($urandom_range(1 << 14, 6 << 16));
                r.qz = 32'($urandom_range(1 << 14, 6 << 16));
            end
        end else begin
            r.command = sbbt_pkg::CMD_TEST;
        end
        return r;
    endfunction

    function automatic sbbt_pkg::t_in make_req(logic [1:0] cmd, logic [31:0] p,
                                               logic [31:0] q, logic [15:0] yw,
                                               logic [30:0] rad, logic pt);
        sbbt_pkg::t_in r;
        r.command = cmd;
        r.px = p; r.py = p; r.pz = p;
        r.qx = q; r.qy = q; r.qz = q;
        r.yaw = yw;
        r.radius = rad;
        r.pass_through = pt;
        return r;
    endfunction

    task automatic add_row(sbbt_pkg::t_in r, t_row_expect e);
        t_row row;
        row.req = r;
        row.exp = e;
        plan.insert(plan.size(), row);
    endtask

    task automatic build_directed();
        t_row_expect none;
        t_row_expect zero_fixed;
        t_row_expect full_fixed;
        none = '0;
        zero_fixed = '{blocked: 1'b0, status: 1'b0, check_fixed: 1'b1};
        full_fixed = '{blocked: 1'b0, status: 1'b1, check_fixed: 1'b1};
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'h8000_0000, 32'h7fff_ffff, 16'hffff,
                         31'h7fff_ffff, 1'b0), zero_fixed);
        add_row(make_req(sbbt_pkg::CMD_UNUSED, 32'hffff_ffff, 32'h7fff_ffff, 16'hffff,
                         31'h7fff_ffff, 1'b1), zero_fixed);
        add_row(make_req(sbbt_pkg::CMD_ADD, 32'h0, 32'h0001_0000, 16'h0000, 31'h0, 1'b0),
                zero_fixed);
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'hfffe_0000, 32'h0002_0000, 16'h0, 31'h0,
                         1'b1), zero_fixed);
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'hfffe_0000, 32'h0002_0000, 16'h0, 31'h0,
                         1'b0), none);
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'h0000_0003, 32'h0000_0005, 16'h0, 31'h0,
                         1'b0), none);
        add_row(make_req(sbbt_pkg::CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 16'h4000,
                         31'h0, 1'b0), zero_fixed);
        add_row(make_req(sbbt_pkg::CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 16'hffff,
                         31'h0, 1'b0), zero_fixed);
        add_row(make_req(sbbt_pkg::CMD_ADD, 32'h0003_0000, 32'hffff_0000, 16'h8000,
                         31'h0, 1'b0), zero_fixed);
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'h0000_0000, 32'h0006_0000, 16'h0,
                         31'h0002_0000, 1'b0), none);
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'h8000_0000, 32'h7fff_ffff, 16'h0,
                         31'h7fff_ffff, 1'b0), none);
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'h7fff_ffff, 32'h8000_0000, 16'h0,
                         31'h0, 1'b0), none);
        add_row(make_req(sbbt_pkg::CMD_CLEAR, 32'h0, 32'h0, 16'h0, 31'h0, 1'b0),
                zero_fixed);
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'h0, 32'h0001_0000, 16'h0, 31'h0, 1'b0),
                zero_fixed);
        for (int i = 0; i < NUM_BOXES; i++) begin
            add_row(make_req(sbbt_pkg::CMD_ADD, 32'(i << 20), 32'h0000_8000,
                             16'(i * 1031), 31'h0, 1'b0), zero_fixed);
        end
        add_row(make_req(sbbt_pkg::CMD_ADD, 32'h0, 32'h0001_0000, 16'h2000, 31'h0, 1'b0),
                full_fixed);
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'h0, 32'h0400_0000, 16'h0, 31'h0, 1'b0),
                none);
        add_row(make_req(sbbt_pkg::CMD_TEST, 32'h8000_0000, 32'h8000_0001, 16'h0, 31'h0,
                         1'b0), none);
        add_row(make_req(sbbt_pkg::CMD_CLEAR, 32'h0, 32'h0, 16'h0, 31'h0, 1'b0),
                zero_fixed);
    endtask

    task automatic send_request(t_row row);
        sbbt_pkg::t_out res;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        res = apply_command(row.req);
        if (row.exp.check_fixed &&
            (res.blocked !== row.exp.blocked || res.status !== row.exp.status)) begin
            $error("fixed row: expected blocked %0d status %0d, predicted %0d %0d",
                   row.exp.blocked, row.exp.status, res.blocked, res.status);
            fail_count++;
        end
        pending_results.insert(pending_results.size(), res);
        i_in <= row.req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
    endtask

    initial begin
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        sbbt_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.blocked !== want.blocked) begin
                    $error("blocked: expected %0d, got %0d", want.blocked, o_out.blocked);
                    fail_count++;
                end
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int tail_wait;
        t_row row;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        fail_count = 0;
        quiet_tail = 1'b0;
        sent_count = 0;
        box_total = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        build_directed();
        foreach (plan[i]) send_request(plan[i]);
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i > RANDOM_REQUESTS - 100) quiet_tail = 1'b1;
            row.req = random_request(box_total >= 40 && $urandom_range(0, 3) == 0 ?
                                     $urandom_range(45, 99) : $urandom_range(0, 99));
            if ($urandom_range(0, 149) == 0) row.req.command = sbbt_pkg::CMD_CLEAR;
            row.exp = '0;
            send_request(row);
        end
        i_in_valid <= 1'b0;
        tail_wait = 0;
        while (pending_results.size() != 0 && tail_wait < 200000) begin
            @(posedge i_clk);
            tail_wait++;
        end
        repeat (6000) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("segment_box_block_test: match");
        end else begin
            $display("segment_box_block_test: mismatch");
        end
        $finish;
    end

    initial begin
        #600ms;
        $display("segment_box_block_test: mismatch");
        $finish;
    end

endmodule
